>>> sv/mfs_pkg.sv
// ----------------------------------------------------------------------------
// mfs_pkg
// types, constants and small arithmetic helpers for the fast magnetosonic
// speed pipeline (signed q16.16)
// ----------------------------------------------------------------------------
`default_nettype none

package mfs_pkg;

  localparam int WORD_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int POS_W   = WORD_W - 1;
  localparam int GAMMA_W = 19;
  localparam int SQRT_W  = 24;

  localparam int DIV_LAT  = POS_W + 1;
  localparam int SQRT_LAT = SQRT_W;

  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 19'd109227;
  localparam logic [POS_W-1:0]   POS_MAX     = {POS_W{1'b1}};

  localparam logic [1:0] AXIS_Y = 2'd2;
  localparam logic [1:0] AXIS_Z = 2'd3;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NONPOS  = 2'd1,
    STATUS_CLAMPED = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] density;
    logic signed [WORD_W-1:0] momentum_x;
    logic signed [WORD_W-1:0] momentum_y;
    logic signed [WORD_W-1:0] momentum_z;
    logic signed [WORD_W-1:0] total_energy;
    logic signed [WORD_W-1:0] field_x;
    logic signed [WORD_W-1:0] field_y;
    logic signed [WORD_W-1:0] field_z;
    logic [1:0]               axis;
  } in_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] gas_pressure;
    logic [POS_W-1:0]         fast_speed;
    status_t                  status;
  } out_rsp_t;

  // square of the magnitude of a signed word
  function automatic logic [2*WORD_W-2:0] mag_sq(input logic signed [WORD_W-1:0] v);
    logic [WORD_W-1:0]   m;
    logic [2*WORD_W-1:0] m2;
    logic [2*WORD_W-1:0] p;
    m  = v[WORD_W-1] ? WORD_W'(-v) : WORD_W'(v);
    m2 = {{WORD_W{1'b0}}, m};
    p  = m2 * m2;
    return p[2*WORD_W-2:0];
  endfunction

  // saturate a word with two guard bits
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WORD_W+1:0] v);
    logic [2:0] top;
    top = v[WORD_W+1:WORD_W-1];
    if (top == 3'b000 || top == 3'b111) begin
      return v[WORD_W-1:0];
    end else if (v[WORD_W+1]) begin
      return {1'b1, {POS_W{1'b0}}};
    end else begin
      return {1'b0, POS_MAX};
    end
  endfunction

  // clamp a wide unsigned value to the positive word range
  function automatic logic [POS_W-1:0] sat_pos(input logic [2*WORD_W-1:0] v);
    return (v > {{(WORD_W+1){1'b0}}, POS_MAX}) ? POS_MAX : v[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/mfs_delay.sv
// ----------------------------------------------------------------------------
// mfs_delay
// enabled shift line that carries side data alongside the arithmetic units
// ----------------------------------------------------------------------------
`default_nettype none

module mfs_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] d,
  output logic      [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

`default_nettype wire

>>> sv/mfs_div.sv
// ----------------------------------------------------------------------------
// mfs_div
// pipelined restoring divider, one quotient bit per stage, quotient
// saturates to all ones when it does not fit
// ----------------------------------------------------------------------------
`default_nettype none

module mfs_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 33,
  parameter int QUO_W = 31
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [QUO_W-1:0] quo
);

  localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [CW-1:0]    rem_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] q_r   [QUO_W+1];
  logic             sat_r [QUO_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= CW'(num);
      den_r[0] <= den;
      q_r[0]   <= '0;
      sat_r[0] <= CW'(num >> QUO_W) >= CW'(den);
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
    localparam int SH = QUO_W - k;
    logic [CW-1:0] trial;
    logic          take;

    assign trial = CW'(den_r[k-1]) << SH;
    assign take  = !sat_r[k-1] && (rem_r[k-1] >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]   <= q_r[k-1] | (QUO_W'(take) << SH);
        sat_r[k] <= sat_r[k-1];
      end
    end

    if (k < QUO_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? rem_r[k-1] - trial : rem_r[k-1];
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign quo = sat_r[QUO_W] ? '1 : q_r[QUO_W];

endmodule

`default_nettype wire

>>> sv/mfs_sqrt.sv
// ----------------------------------------------------------------------------
// mfs_sqrt
// pipelined integer square root, one root bit per stage, truncating
// ----------------------------------------------------------------------------
`default_nettype none

module mfs_sqrt #(
  parameter int ROOT_W = 24
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [2*ROOT_W-1:0] radicand,
  output logic      [ROOT_W-1:0]   root
);

  localparam int RAD_W = 2 * ROOT_W;

  logic [RAD_W-1:0] op_r  [ROOT_W-1];
  logic [RAD_W-1:0] res_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam logic [RAD_W-1:0] ONE = RAD_W'(1) << (2 * (ROOT_W - 1 - k));
    logic [RAD_W-1:0] op_in;
    logic [RAD_W-1:0] res_in;
    logic [RAD_W-1:0] trial;
    logic             take;

    if (k == 0) begin : g_first
      assign op_in  = radicand;
      assign res_in = '0;
    end else begin : g_next
      assign op_in  = op_r[k-1];
      assign res_in = res_r[k-1];
    end

    assign trial = res_in + ONE;
    assign take  = op_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        res_r[k] <= take ? (res_in >> 1) + ONE : res_in >> 1;
      end
    end

    if (k < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          op_r[k] <= take ? op_in - trial : op_in;
        end
      end
    end
  end

  assign root = res_r[ROOT_W-1][ROOT_W-1:0];

endmodule

`default_nettype wire

>>> sv/mhd_fast_magnetosonic_speed.sv
// ----------------------------------------------------------------------------
// mhd_fast_magnetosonic_speed
// path from request to result runs through two 32-stage dividers and two
// 24-stage square roots in series. one request per cycle; a held
// result stalls the whole pipeline. reset clears all valid bits and sets
// gamma to five thirds
// ----------------------------------------------------------------------------
`default_nettype none

module mhd_fast_magnetosonic_speed (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire mfs_pkg::in_req_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output mfs_pkg::out_rsp_t                  out_data,
  input  wire logic                          cfg_we,
  input  wire logic [mfs_pkg::GAMMA_W-1:0]   cfg_wdata
);

  localparam int W     = mfs_pkg::WORD_W;
  localparam int PW    = mfs_pkg::POS_W;
  localparam int FW    = mfs_pkg::FRAC_W;
  localparam int GW    = mfs_pkg::GAMMA_W;
  localparam int SW    = mfs_pkg::SQRT_W;
  localparam int DL    = mfs_pkg::DIV_LAT;
  localparam int SL    = mfs_pkg::SQRT_LAT;
  localparam int RAD_W = 2 * SW;
  localparam int LAT   = 3 + DL + 4 + DL + 3 + SL + 1 + SL + 1;
  localparam int D_NP  = LAT - 4;
  localparam int D_P   = LAT - 1 - (6 + DL);
  localparam int D_CD  = LAT - 1 - (10 + 2 * DL);
  localparam logic [PW-1:0] MAX = mfs_pkg::POS_MAX;

  logic           en;
  logic [LAT-1:0] vld_r;
  logic [GW-1:0]  gamma_r;

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      gamma_r <= mfs_pkg::GAMMA_RESET;
    end else begin
      if (en) begin
        vld_r <= {vld_r[LAT-2:0], in_valid};
      end
      if (cfg_we) begin
        gamma_r <= cfg_wdata;
      end
    end
  end

  // squares and sums
  mfs_pkg::in_req_t      in_r;
  logic [2*W-2:0]        sqm_r [3];
  logic [2*W-2:0]        sqb_r [3];
  logic signed [W-1:0]   rho2_r, energy2_r;
  logic [1:0]            axis2_r;
  logic                  nonpos2_r;
  logic [2*W-1:0]        mom2_r, mag2_r;
  logic [2*W-2:0]        bk2_r;
  logic signed [W-1:0]   rho3_r, energy3_r;
  logic                  nonpos3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      in_r      <= in_data;
      sqm_r[0]  <= mfs_pkg::mag_sq(in_r.momentum_x);
      sqm_r[1]  <= mfs_pkg::mag_sq(in_r.momentum_y);
      sqm_r[2]  <= mfs_pkg::mag_sq(in_r.momentum_z);
      sqb_r[0]  <= mfs_pkg::mag_sq(in_r.field_x);
      sqb_r[1]  <= mfs_pkg::mag_sq(in_r.field_y);
      sqb_r[2]  <= mfs_pkg::mag_sq(in_r.field_z);
      rho2_r    <= in_r.density;
      energy2_r <= in_r.total_energy;
      axis2_r   <= in_r.axis;
      nonpos2_r <= in_r.density[W-1] || (in_r.density == '0);
      mom2_r    <= (2*W)'(sqm_r[0]) + (2*W)'(sqm_r[1]) + (2*W)'(sqm_r[2]);
      mag2_r    <= (2*W)'(sqb_r[0]) + (2*W)'(sqb_r[1]) + (2*W)'(sqb_r[2]);
      case (axis2_r)
        mfs_pkg::AXIS_Y: bk2_r <= sqb_r[1];
        mfs_pkg::AXIS_Z: bk2_r <= sqb_r[2];
        default:         bk2_r <= sqb_r[0];
      endcase
      rho3_r    <= rho2_r;
      energy3_r <= energy2_r;
      nonpos3_r <= nonpos2_r;
    end
  end

  // kinetic energy, b and bk quotients
  logic [PW-1:0] kin_q, b_q, bk_q, half3;
  logic [PW-1:0] half35, b71, bk71;
  logic [W-1:0]  energy35_u, rho39_u;

  assign half3 = mfs_pkg::sat_pos(mag2_r >> (FW + 1));

  mfs_div #(.NUM_W(2*W), .DEN_W(W+1), .QUO_W(PW)) u_div_kin (
    .clk(clk), .en(en), .num(mom2_r), .den({rho3_r, 1'b0}), .quo(kin_q)
  );

  mfs_div #(.NUM_W(2*W), .DEN_W(W+1), .QUO_W(PW)) u_div_b (
    .clk(clk), .en(en), .num(mag2_r), .den({1'b0, rho3_r}), .quo(b_q)
  );

  mfs_div #(.NUM_W(2*W), .DEN_W(W+1), .QUO_W(PW)) u_div_bk (
    .clk(clk), .en(en), .num({1'b0, bk2_r}), .den({1'b0, rho3_r}), .quo(bk_q)
  );

  mfs_delay #(.WIDTH(W + PW), .DEPTH(DL)) u_dly_eh (
    .clk(clk), .en(en), .d({energy3_r, half3}), .q({energy35_u, half35})
  );

  mfs_delay #(.WIDTH(W), .DEPTH(DL + 4)) u_dly_rho (
    .clk(clk), .en(en), .d(rho3_r), .q(rho39_u)
  );

  mfs_delay #(.WIDTH(2 * PW), .DEPTH(DL + 4)) u_dly_bbk (
    .clk(clk), .en(en), .d({b_q, bk_q}), .q({b71, bk71})
  );

  // pressure
  logic signed [W-1:0]      inner_r;
  logic signed [W-1:0]      e1;
  logic signed [W+1:0]      d1, d2;
  logic signed [GW+1:0]     gm1;
  logic signed [GW+W+1:0]   gprod_r;
  logic [GW+W+1:0]          pmag;
  logic [PW-1:0]            p_nxt, p38_r;
  logic                     clamp_p_nxt, clamp_p38_r;
  logic [GW+PW-1:0]         ap_r;

  always_comb begin
    d1  = {{2{energy35_u[W-1]}}, energy35_u} - {3'b000, kin_q};
    e1  = mfs_pkg::sat_word(d1);
    d2  = {{2{e1[W-1]}}, e1} - {3'b000, half35};
    gm1 = {2'b00, gamma_r} - (GW+2)'(1 << FW);
  end

  always_comb begin
    pmag = gprod_r[GW+W+1] ? (GW+W+2)'(-gprod_r) : (GW+W+2)'(gprod_r);
    if (gprod_r[GW+W+1]) begin
      p_nxt       = '0;
      clamp_p_nxt = |pmag[GW+W+1:FW];
    end else begin
      p_nxt       = (|pmag[GW+W+1:FW+PW]) ? MAX : pmag[FW+PW-1:FW];
      clamp_p_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inner_r     <= mfs_pkg::sat_word(d2);
      gprod_r     <= gm1 * inner_r;
      p38_r       <= p_nxt;
      clamp_p38_r <= clamp_p_nxt;
      ap_r        <= {{PW{1'b0}}, gamma_r} * {{GW{1'b0}}, p38_r};
    end
  end

  // a quotient and discriminant
  logic [PW-1:0]   a_q, s_r, t4_r, s98, disc_r;
  logic [2*PW-1:0] tprod_r, ssq_r;
  logic [W-1:0]    sum_ab, dd;
  logic [PW-1:0]   qs;
  logic [2*PW-FW-1:0] tq;
  logic            clamp_d_r;

  mfs_div #(.NUM_W(2*W), .DEN_W(W+1), .QUO_W(PW)) u_div_a (
    .clk(clk), .en(en), .num((2*W)'(ap_r)), .den({1'b0, rho39_u}), .quo(a_q)
  );

  always_comb begin
    sum_ab = {1'b0, a_q} + {1'b0, b71};
    tq     = tprod_r[2*PW-1:FW];
    qs     = (|ssq_r[2*PW-1:FW+PW]) ? MAX : ssq_r[FW+PW-1:FW];
    dd     = {1'b0, qs} - {1'b0, t4_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r       <= sum_ab[W-1] ? MAX : sum_ab[PW-1:0];
      tprod_r   <= {{PW{1'b0}}, a_q} * {{PW{1'b0}}, bk71};
      ssq_r     <= {{PW{1'b0}}, s_r} * {{PW{1'b0}}, s_r};
      t4_r      <= (|tq[2*PW-FW-1:PW-2]) ? MAX : {tq[PW-3:0], 2'b00};
      clamp_d_r <= dd[W-1];
      disc_r    <= dd[W-1] ? '0 : dd[PW-1:0];
    end
  end

  mfs_delay #(.WIDTH(PW), .DEPTH(SL + 2)) u_dly_s (
    .clk(clk), .en(en), .d(s_r), .q(s98)
  );

  // nested roots
  logic [SW-1:0]  root1, speed;
  logic [W-1:0]   sum_sr;
  logic [PW-1:0]  sum_sat;
  logic [PW-2:0]  outer_r;

  mfs_sqrt #(.ROOT_W(SW)) u_sqrt_disc (
    .clk(clk), .en(en), .radicand(RAD_W'({disc_r, {FW{1'b0}}})), .root(root1)
  );

  always_comb begin
    sum_sr  = {1'b0, s98} + {{(W-SW){1'b0}}, root1};
    sum_sat = sum_sr[W-1] ? MAX : sum_sr[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      outer_r <= sum_sat[PW-1:1];
    end
  end

  mfs_sqrt #(.ROOT_W(SW)) u_sqrt_outer (
    .clk(clk), .en(en), .radicand(RAD_W'({outer_r, {FW{1'b0}}})), .root(speed)
  );

  // result
  logic          nonpos_e, clamp_p_e, clamp_d_e;
  logic [PW-1:0] p_e;
  mfs_pkg::out_rsp_t out_r;

  mfs_delay #(.WIDTH(1), .DEPTH(D_NP)) u_dly_np (
    .clk(clk), .en(en), .d(nonpos3_r), .q(nonpos_e)
  );

  mfs_delay #(.WIDTH(PW + 1), .DEPTH(D_P)) u_dly_p (
    .clk(clk), .en(en), .d({p38_r, clamp_p38_r}), .q({p_e, clamp_p_e})
  );

  mfs_delay #(.WIDTH(1), .DEPTH(D_CD)) u_dly_cd (
    .clk(clk), .en(en), .d(clamp_d_r), .q(clamp_d_e)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      if (nonpos_e) begin
        out_r.gas_pressure <= '0;
        out_r.fast_speed   <= '0;
        out_r.status       <= mfs_pkg::STATUS_NONPOS;
      end else begin
        out_r.gas_pressure <= {1'b0, p_e};
        out_r.fast_speed   <= {{(PW-SW){1'b0}}, speed};
        out_r.status       <= (clamp_p_e || clamp_d_e) ? mfs_pkg::STATUS_CLAMPED
                                                       : mfs_pkg::STATUS_OK;
      end
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

>>> tb/mhd_fast_magnetosonic_speed_tb.sv
// ----------------------------------------------------------------------------
// mhd_fast_magnetosonic_speed_tb
// drives cell states through the fast magnetosonic speed pipeline and checks
// pressure, speed and status of every result against a bit-exact predictor
// ----------------------------------------------------------------------------
`default_nettype none

module mhd_fast_magnetosonic_speed_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [127:0] POS_LIM = 128'h7fffffff;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  mfs_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mfs_pkg::out_rsp_t out_data;
  logic cfg_we = 1'b0;
  logic [mfs_pkg::GAMMA_W-1:0] cfg_wdata = '0;

  mfs_pkg::in_req_t request_queue[$];
  mfs_pkg::out_rsp_t expected_results[$];
  logic [mfs_pkg::GAMMA_W-1:0] gamma_now;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int sent_count = 0;
  int received_count = 0;
  int quiet_cycles = 0;
  int clamp_seen = 0;
  int nonpos_seen = 0;

  always #2 clk = ~clk;

  mhd_fast_magnetosonic_speed u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  function automatic logic [127:0] mag_of(input logic signed [31:0] v);
    logic [127:0] m;
    m = v[31] ? 128'(-{32'hffffffff, v}) & 128'hffffffff : 128'(v[30:0]);
    if (v == 32'sh80000000) m = 128'h80000000;
    return m;
  endfunction

  function automatic logic signed [63:0] clamp32(input logic signed [127:0] v);
    if (v > $signed(POS_LIM)) return 64'sh7fffffff;
    if (v < -$signed(POS_LIM) - 1) return -64'sh80000000;
    return 64'(v);
  endfunction

  function automatic logic signed [63:0] pos_clamp(input logic [127:0] v);
    return (v > POS_LIM) ? 64'sh7fffffff : 64'(v);
  endfunction

  // fixed point product truncated toward zero, saturated
  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [127:0] p;
    logic [127:0] mag;
    p = 128'(a) * 128'(b);
    mag = p[127] ? 128'(-p) : 128'(p);
    mag = mag >> mfs_pkg::FRAC_W;
    return p[127] ? clamp32(-$signed(mag)) : clamp32($signed(mag));
  endfunction

  function automatic logic [127:0] int_sqrt(input logic [127:0] n);
    logic [127:0] r;
    logic [127:0] c;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic mfs_pkg::out_rsp_t predict_wave_speed(input mfs_pkg::in_req_t rq,
      input logic [mfs_pkg::GAMMA_W-1:0] g);
    mfs_pkg::out_rsp_t r;
    logic signed [63:0] rho, kin, half_mag, inner, gm1, p, a, b, bk, s, t, disc, root, outer;
    logic [127:0] mom2, mag2, bk2, sp;
    logic signed [31:0] fsel;
    r = '0;
    r.status = mfs_pkg::STATUS_OK;
    rho = 64'(rq.density);
    if (rho <= 0) begin
      r.status = mfs_pkg::STATUS_NONPOS;
      return r;
    end
    mom2 = mag_of(rq.momentum_x) ** 2 + mag_of(rq.momentum_y) ** 2
         + mag_of(rq.momentum_z) ** 2;
    mag2 = mag_of(rq.field_x) ** 2 + mag_of(rq.field_y) ** 2 + mag_of(rq.field_z) ** 2;
    kin = pos_clamp(mom2 / (2 * 128'(rho)));
    half_mag = pos_clamp(mag2 >> (mfs_pkg::FRAC_W + 1));
    inner = clamp32(128'(64'(rq.total_energy)) - 128'(kin) - 128'(half_mag));
    inner = clamp32(128'(64'(rq.total_energy)) - 128'(kin));
    inner = clamp32(128'(inner) - 128'(half_mag));
    gm1 = 64'(g) - 64'sd65536;
    p = fx_mul(gm1, inner);
    if (p < 0) begin
      p = 0;
      r.status = mfs_pkg::STATUS_CLAMPED;
    end
    a = pos_clamp((128'(g) * 128'(p)) / 128'(rho));
    b = pos_clamp(mag2 / 128'(rho));
    fsel = (rq.axis == mfs_pkg::AXIS_Y) ? rq.field_y :
           (rq.axis == mfs_pkg::AXIS_Z) ? rq.field_z : rq.field_x;
    bk2 = mag_of(fsel) ** 2;
    bk = pos_clamp(bk2 / 128'(rho));
    s = clamp32(128'(a) + 128'(b));
    t = fx_mul(a, bk);
    t = clamp32(128'(clamp32(128'(t) + 128'(t))) + 128'(clamp32(128'(t) + 128'(t))));
    disc = clamp32(128'(fx_mul(s, s)) - 128'(t));
    if (disc < 0) begin
      disc = 0;
      r.status = mfs_pkg::STATUS_CLAMPED;
    end
    root = pos_clamp(int_sqrt(128'(disc) << mfs_pkg::FRAC_W));
    outer = clamp32(128'(s) + 128'(root)) >>> 1;
    sp = int_sqrt(128'(outer) << mfs_pkg::FRAC_W);
    if (sp > POS_LIM) sp = POS_LIM;
    r.gas_pressure = p[31:0];
    r.fast_speed = sp[30:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_word(input int scale);
    case (scale)
      0: return $urandom();
      1: return $urandom_range(1 << 20, 1 << 16) | 32'h0;
      2: return 32'($signed($urandom_range(4 << 16, 0)) - (2 << 16));
      default: return 32'($signed($urandom_range(1 << 24, 0)) - (1 << 23));
    endcase
  endfunction

  function automatic mfs_pkg::in_req_t random_cell();
    mfs_pkg::in_req_t rq;
    int k;
    k = $urandom_range(9, 0);
    rq.density = (k == 0) ? rand_word(0) : rand_word(1);
    rq.momentum_x = rand_word(k == 1 ? 0 : 2 + (k & 1));
    rq.momentum_y = rand_word(k == 2 ? 0 : 2 + (k & 1));
    rq.momentum_z = rand_word(k == 3 ? 0 : 2);
    rq.total_energy = (k >= 7) ? rand_word(0) : 32'($urandom_range(1 << 26, 0));
    rq.field_x = rand_word(k == 4 ? 0 : 2 + (k & 1));
    rq.field_y = rand_word(k == 5 ? 0 : 2);
    rq.field_z = rand_word(k == 6 ? 0 : 3);
    rq.axis = 2'($urandom_range(3, 0));
    return rq;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (in_valid) begin
          expected_results.push_back(predict_wave_speed(in_data, gamma_now));
          sent_count++;
        end
        if (request_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_data <= request_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        received_count++;
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result %h", $time, out_data);
        end else begin
          mfs_pkg::out_rsp_t e;
          e = expected_results.pop_front();
          if (e.status == mfs_pkg::STATUS_CLAMPED) clamp_seen++;
          if (e.status == mfs_pkg::STATUS_NONPOS) nonpos_seen++;
          if (e.gas_pressure !== out_data.gas_pressure) begin
            error_count++;
            $display("%0t: gas_pressure expected %h actual %h", $time, e.gas_pressure,
                     out_data.gas_pressure);
          end
          if (e.fast_speed !== out_data.fast_speed) begin
            error_count++;
            $display("%0t: fast_speed expected %h actual %h", $time, e.fast_speed,
                     out_data.fast_speed);
          end
          if (e.status !== out_data.status) begin
            error_count++;
            $display("%0t: status expected %0d actual %0d", $time, e.status,
                     out_data.status);
          end
        end
      end
      out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic drain();
    while (request_queue.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gamma(input logic [mfs_pkg::GAMMA_W-1:0] g);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    gamma_now = g;
  endtask

  task automatic load_directed();
    mfs_pkg::in_req_t rq;
    logic [31:0] edges [4];
    edges = '{32'h80000000, 32'h7fffffff, 32'h00000000, 32'hffffffff};
    for (int i = 0; i < 16; i++) begin
      rq.density = (i < 4) ? edges[i] : 32'h00010000 + 32'(i);
      rq.momentum_x = edges[i % 4];
      rq.momentum_y = edges[(i + 1) % 4];
      rq.momentum_z = edges[(i + 2) % 4];
      rq.total_energy = edges[(i / 4) % 4];
      rq.field_x = edges[(i + 3) % 4];
      rq.field_y = (i & 1) ? 32'h00020000 : 32'hfffe0000;
      rq.field_z = edges[i % 4];
      rq.axis = 2'(i);
      request_queue.push_back(rq);
    end
    for (int i = 0; i < 8; i++) begin
      rq = '0;
      rq.density = (i == 0) ? 32'h00000001 : 32'h00010000;
      rq.total_energy = (i < 4) ? 32'h00030000 : 32'hfff00000;
      rq.field_x = 32'h00010000;
      rq.field_y = (i & 1) ? 32'h00008000 : 32'h0;
      rq.field_z = 32'h7fffffff;
      rq.momentum_y = 32'h00004000;
      rq.axis = 2'(i);
      request_queue.push_back(rq);
    end
  endtask

  task automatic run_phase(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) request_queue.push_back(random_cell());
    drain();
  endtask

  initial begin
    logic [mfs_pkg::GAMMA_W-1:0] gammas [5];
    gammas = '{19'd65537, 19'd262144, 19'd109227, 19'd98304, 19'd0};
    gamma_now = mfs_pkg::GAMMA_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_gamma(19'd109227);
    load_directed();
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) gammas[4] = 19'($urandom_range(262144, 65537));
      write_gamma(gammas[ph]);
      run_phase(60, 0, 0);
      run_phase(60, 52, 0);
      run_phase(60, 0, 52);
      run_phase(60, 30, 30);
    end
    write_gamma(19'h7ffff);
    run_phase(20, 30, 30);
    write_gamma(19'd0);
    run_phase(20, 0, 0);
    $display("sent %0d cell states over seven gamma settings and four idling mixes",
             sent_count);
    $display("received %0d results, %0d clamped, %0d nonpositive density",
             received_count, clamp_seen, nonpos_seen);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
